[rtl/bmp8_palette_stream_decoder_defines.svh]
// assertion macros shared by the checker of the palette bmp decoder
// no dependencies; pulled in by `include where assertions are written
`ifndef BMP8_PALETTE_STREAM_DECODER_DEFINES_SVH
`define BMP8_PALETTE_STREAM_DECODER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define BMP8_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define BMP8_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/bmp8pal_pkg.sv]
// types and constants of the palette bmp stream decoder
// no dependencies; imported by the front end, the queue and the top level
package bmp8pal_pkg;

	localparam int MAX_DIM       = 4096;
	localparam int PALETTE_DEPTH = 256;
	localparam int HEADER_BYTES  = 54;
	localparam int WIDTH_OFS     = 18;
	localparam int HEIGHT_OFS    = 22;
	localparam int COUNT_OFS     = 46;
	localparam int QUEUE_DEPTH   = 4;

	localparam int DIM_W     = $clog2(MAX_DIM + 1);
	localparam int HDR_W     = $clog2(HEADER_BYTES);
	localparam int PAL_CNT_W = $clog2(PALETTE_DEPTH + 1);
	localparam int PAL_AW    = $clog2(PALETTE_DEPTH);
	localparam int IDX_CMP_W = 9;
	localparam int COLOR_W   = 24;
	localparam int OUT_W     = 12;
	localparam int Q_AW      = $clog2(QUEUE_DEPTH);
	localparam int Q_CNT_W   = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_PALETTE,
		PH_PIXELS,
		PH_PADDING,
		PH_DONE,
		PH_FAULT
	} phase_t;

	typedef struct packed {
		logic             last;
		logic [OUT_W-1:0] col;
		logic [OUT_W-1:0] row;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
	} out_item_t;

	typedef struct packed {
		logic             valid;
		logic [Q_CNT_W-1:0] level;
	} q_status_t;

endpackage

[rtl/bmp8pal_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module bmp8pal_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/bmp8pal_front.sv]
// front end: header parse, palette load, pixel/padding classification, palette lookup
// depends on bmp8pal_pkg and bmp8pal_ram
module bmp8pal_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             in_byte,
	input  logic                   in_sof,
	input  bmp8pal_pkg::q_status_t q_status,
	output logic                   s1_valid,
	output bmp8pal_pkg::out_item_t s1_item
);
	import bmp8pal_pkg::*;

	phase_t phase_q, phase_e, phase_d;
	logic [HDR_W-1:0]     hdr_q, hdr_e;
	logic [31:0]          width_q, height_q, count_q;
	logic [PAL_CNT_W-1:0] pal_cnt_q, fill_q, pal_cnt_sat;
	logic [1:0]           ebi_q;
	logic [7:0]           blu_q, grn_q;
	logic [DIM_W-1:0]     col_q, row_q, wd, ht, row_next;
	logic [1:0]           pad_q, pad_new;
	logic [1:0]           w_lane, h_lane, c_lane;
	logic                 accept, hdr_done, dim_bad, entry_done, fill_done, col_last;
	logic                 pix_fire, ram_we;
	logic [Q_CNT_W:0]     occupancy;

	logic                 s1_valid_q;
	logic [OUT_W-1:0]     row_s1, col_s1;
	logic                 last_s1, hit_s1;
	logic [COLOR_W-1:0]   color;

	// a start of file forces the header phase for this very byte
	assign phase_e = in_sof ? PH_HEADER : phase_q;
	assign hdr_e   = in_sof ? '0 : hdr_q;

	assign occupancy = {1'b0, q_status.level} + (Q_CNT_W+1)'(s1_valid_q);
	assign in_ready  = occupancy < (Q_CNT_W+1)'(QUEUE_DEPTH);
	assign accept    = in_valid & in_ready;

	assign wd       = width_q[DIM_W-1:0];
	assign ht       = height_q[DIM_W-1:0];
	assign row_next = row_q + DIM_W'(1);
	assign col_last = (col_q + DIM_W'(1)) == wd;
	assign pad_new  = 2'(2'd0 - wd[1:0]);

	assign hdr_done = hdr_e == HDR_W'(HEADER_BYTES - 1);
	assign dim_bad  = (width_q == 32'd0) || (width_q > 32'(MAX_DIM)) ||
		(height_q == 32'd0) || (height_q > 32'(MAX_DIM));
	assign pal_cnt_sat = ((count_q == 32'd0) || (count_q > 32'(PALETTE_DEPTH))) ?
		PAL_CNT_W'(PALETTE_DEPTH) : PAL_CNT_W'(count_q);

	assign entry_done = ebi_q == 2'd3;
	assign fill_done  = (fill_q + PAL_CNT_W'(1)) >= pal_cnt_q;

	assign w_lane = 2'(hdr_e - HDR_W'(WIDTH_OFS));
	assign h_lane = 2'(hdr_e - HDR_W'(HEIGHT_OFS));
	assign c_lane = 2'(hdr_e - HDR_W'(COUNT_OFS));

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			phase_d = phase_e;
			case (phase_e)
				PH_HEADER: begin
					if (hdr_done) begin
						phase_d = dim_bad ? PH_FAULT : PH_PALETTE;
					end
				end
				PH_PALETTE: begin
					if (entry_done && fill_done) begin
						phase_d = PH_PIXELS;
					end
				end
				PH_PIXELS: begin
					if (col_last) begin
						if (pad_new != 2'd0) begin
							phase_d = PH_PADDING;
						end else if (row_next >= ht) begin
							phase_d = PH_DONE;
						end
					end
				end
				PH_PADDING: begin
					if (pad_q == 2'd1) begin
						phase_d = (row_q >= ht) ? PH_DONE : PH_PIXELS;
					end
				end
				default: phase_d = phase_e;
			endcase
		end
	end

	// per-phase actions
	always_comb begin
		pix_fire = 1'b0;
		ram_we   = 1'b0;
		case (phase_e)
			PH_PALETTE: ram_we   = accept && (ebi_q == 2'd2);
			PH_PIXELS:  pix_fire = accept;
			default: begin
				pix_fire = 1'b0;
				ram_we   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_q     <= '0;
			width_q   <= '0;
			height_q  <= '0;
			count_q   <= '0;
			pal_cnt_q <= '0;
			fill_q    <= '0;
			ebi_q     <= '0;
			row_q     <= '0;
			col_q     <= '0;
			pad_q     <= '0;
		end else begin
			phase_q <= phase_d;
			if (accept) begin
				case (phase_e)
					PH_HEADER: begin
						hdr_q <= hdr_e + HDR_W'(1);
						if (hdr_e inside {[WIDTH_OFS:WIDTH_OFS+3]}) begin
							width_q[8*w_lane +: 8] <= in_byte;
						end
						if (hdr_e inside {[HEIGHT_OFS:HEIGHT_OFS+3]}) begin
							height_q[8*h_lane +: 8] <= in_byte;
						end
						if (hdr_e inside {[COUNT_OFS:COUNT_OFS+3]}) begin
							count_q[8*c_lane +: 8] <= in_byte;
						end
						if (hdr_done) begin
							pal_cnt_q <= pal_cnt_sat;
							fill_q    <= '0;
							ebi_q     <= '0;
						end
					end
					PH_PALETTE: begin
						ebi_q <= ebi_q + 2'd1;
						if (entry_done) begin
							fill_q <= fill_q + PAL_CNT_W'(1);
							if (fill_done) begin
								row_q <= '0;
								col_q <= '0;
							end
						end
					end
					PH_PIXELS: begin
						if (col_last) begin
							col_q <= '0;
							row_q <= row_next;
							pad_q <= pad_new;
						end else begin
							col_q <= col_q + DIM_W'(1);
						end
					end
					PH_PADDING: pad_q <= pad_q - 2'd1;
					default: pad_q <= pad_q;
				endcase
			end
		end
	end

	// blue and green wait for the red byte, then the entry is written whole
	always_ff @(posedge clk) begin
		if (accept && (phase_e == PH_PALETTE)) begin
			if (ebi_q == 2'd0) begin
				blu_q <= in_byte;
			end
			if (ebi_q == 2'd1) begin
				grn_q <= in_byte;
			end
		end
	end

	bmp8pal_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (PALETTE_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q[PAL_AW-1:0]),
		.wdata ({in_byte, grn_q, blu_q}),
		.re    (pix_fire),
		.raddr (in_byte[PAL_AW-1:0]),
		.rdata (color)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= pix_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_fire) begin
			row_s1  <= OUT_W'(ht - DIM_W'(1) - row_q);
			col_s1  <= OUT_W'(col_q);
			last_s1 <= col_last && (row_next == ht);
			hit_s1  <= IDX_CMP_W'(in_byte) < IDX_CMP_W'(pal_cnt_q);
		end
	end

	assign s1_valid       = s1_valid_q;
	assign s1_item.blue   = hit_s1 ? color[7:0]   : 8'd0;
	assign s1_item.green  = hit_s1 ? color[15:8]  : 8'd0;
	assign s1_item.red    = hit_s1 ? color[23:16] : 8'd0;
	assign s1_item.row    = row_s1;
	assign s1_item.col    = col_s1;
	assign s1_item.last   = last_s1;

endmodule

[rtl/bmp8pal_queue.sv]
// short result queue between the front end and the output port
// depends on bmp8pal_pkg
module bmp8pal_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  bmp8pal_pkg::out_item_t push_item,
	output bmp8pal_pkg::q_status_t status,
	output logic                   out_valid,
	input  logic                   out_ready,
	output bmp8pal_pkg::out_item_t out_item
);
	import bmp8pal_pkg::*;

	out_item_t          mem_q [QUEUE_DEPTH];
	logic [Q_AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	logic               pop;

	assign out_valid = count_q != '0;
	assign pop       = out_valid & out_ready;
	assign out_item  = mem_q[rd_ptr_q];

	assign status.valid = out_valid;
	assign status.level = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + Q_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - Q_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

[rtl/bmp8_palette_stream_decoder.sv]
// top level of the 8-bit palette bmp stream decoder
// depends on bmp8pal_pkg, bmp8pal_front and bmp8pal_queue
//
// input stream: one file byte per transfer on s_axis_tdata[7:0]; s_axis_tuser
// high marks the first byte of a new file and restarts header parsing.
// output stream: one transfer per pixel byte with the palette color, the
// flipped row and the column; m_axis_tlast is high on the last pixel.
// header, palette and row padding bytes give no output; a width or height of
// zero or above 4096 gives no output until the next start of file.
// throughput: one byte per cycle sustained while not stalled, any byte kind.
// pixel path: an accepted pixel byte is read from the palette ram and
// registered, then written to the result queue that drives m_axis_tvalid.
// reset: back to header parsing with an empty queue; the palette ram is
// not cleared, only entries loaded from the current file are looked up.
// receiver stall: the queue keeps filling; s_axis_tready drops once the
// queue and the lookup stage together hold four results.
module bmp8_palette_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tuser,  // [0] start_of_file
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // [7:0] pixel_blue, [15:8] pixel_green,
	                                   // [23:16] pixel_red, [35:24] image_row,
	                                   // [47:36] image_col
	output logic        m_axis_tlast   // last_pixel
);
	import bmp8pal_pkg::*;

	logic      s1_valid;
	out_item_t s1_item, head;
	q_status_t q_status;

	bmp8pal_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_sof   (s_axis_tuser),
		.q_status (q_status),
		.s1_valid (s1_valid),
		.s1_item  (s1_item)
	);

	bmp8pal_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s1_valid),
		.push_item (s1_item),
		.status    (q_status),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_item  (head)
	);

	assign m_axis_tdata = {head.col, head.row, head.red, head.green, head.blue};
	assign m_axis_tlast = head.last;

endmodule

[rtl/bmp8pal_checker.sv]
// port-level checker for the palette bmp stream decoder, bound to the top level
// depends on bmp8_palette_stream_decoder_defines.svh
`include "bmp8_palette_stream_decoder_defines.svh"

module bmp8pal_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [7:0]  s_axis_tdata,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	// a stalled result stays offered
	`BMP8_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

	// a stalled result keeps its payload
	`BMP8_ASSERT_NXT(a_out_stable, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast), "result payload changed while stalled")

	// a result appears only after an input transfer, through the lookup stage and the queue
	`BMP8_ASSERT_IMP(a_out_cause, clk, arst_n, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2), "result without matching input transfer")

	// input back-pressure only builds up behind a stalled output
	`BMP8_ASSERT_IMP(a_ready_drop, clk, arst_n, $fell(s_axis_tready), $past(m_axis_tvalid && !m_axis_tready), "ready dropped without output stall")

endmodule

bind bmp8_palette_stream_decoder bmp8pal_checker u_checker (.*);
